FILE: rtl/ugf_pkg.sv
// ugf_pkg: shared types, constants and glyph lookup functions for the UTF-8
// glyph filter decoder. No dependencies; used by all rtl files but ugf_checker.
package ugf_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [20:0] CP_REPL     = 21'h00FFFD;
    localparam logic [20:0] CP_ZWJ      = 21'h00200D;
    localparam logic [20:0] CP_FEMALE   = 21'h002640;
    localparam logic [20:0] CP_MALE     = 21'h002642;
    localparam logic [20:0] CP_VS15     = 21'h00FE0E;
    localparam logic [20:0] CP_VS16     = 21'h00FE0F;
    localparam logic [20:0] CP_TONE_LO  = 21'h01F3FB;
    localparam logic [20:0] CP_TONE_HI  = 21'h01F3FF;
    localparam logic [20:0] CP_NBSP     = 21'h0000A0;
    localparam logic [20:0] CP_NNBSP    = 21'h00202F;
    localparam logic [20:0] CP_FIGSP    = 21'h002007;
    localparam logic [20:0] CP_DBL_EXCL = 21'h00203C;
    localparam logic [20:0] CP_HUNDRED  = 21'h01F4AF;
    localparam logic [20:0] CP_CYR_LO   = 21'h000410;
    localparam logic [20:0] CP_CYR_HI   = 21'h00044F;
    localparam logic [15:0] ICON_CHECK  = 16'hF00C;
    localparam logic [15:0] ICON_HEART  = 16'hF004;
    localparam logic [15:0] ICON_SMILE  = 16'hF5B8;
    localparam logic [15:0] ICON_GRIN   = 16'hF580;
    localparam logic [15:0] ICON_HUG    = 16'hF4C2;
    localparam logic [15:0] ICON_SMIRK  = 16'hF11A;
    localparam logic [15:0] ICON_QMARK  = 16'hF128;

    // What one accepted beat leaves for the classifier.
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_REPL = 2'd1,
        KIND_FILT = 2'd2
    } ugf_kind_t;

    // One queued job: 1..4 output bytes of a single input beat.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            data;
        logic            last;
    } ugf_job_t;

    function automatic logic is_dropped(input logic [20:0] cp);
        return cp == CP_ZWJ || cp == CP_FEMALE || cp == CP_MALE ||
               cp == CP_VS15 || cp == CP_VS16 ||
               (cp >= CP_TONE_LO && cp <= CP_TONE_HI);
    endfunction

    function automatic logic in_font(input logic [20:0] cp);
        return (cp >= 21'h20 && cp <= 21'h7E) ||
               cp == 21'hC4 || cp == 21'hC5 || cp == 21'hC9 || cp == 21'hD6 ||
               cp == 21'hE4 || cp == 21'hE5 || cp == 21'hE9 || cp == 21'hF6 ||
               (cp >= CP_CYR_LO && cp <= CP_CYR_HI) ||
               cp == 21'hB0 || cp == CP_REPL;
    endfunction

    // Emoji to icon code point; 0 means no icon.
    function automatic logic [15:0] icon_of(input logic [20:0] cp);
        logic [15:0] icon;
        icon = 16'h0000;
        unique case (cp)
            21'h1F602: icon = 16'hF588;
            21'h1F923: icon = 16'hF586;
            21'h1F60D: icon = 16'hF584;
            21'h1F60A: icon = ICON_SMILE;
            21'h1F60C: icon = ICON_SMILE;
            21'h1F607: icon = ICON_SMILE;
            21'h1F642: icon = ICON_SMILE;
            21'h0263A: icon = ICON_SMILE;
            21'h1F62D: icon = 16'hF5B3;
            21'h1F618: icon = 16'hF598;
            21'h1F605: icon = 16'hF583;
            21'h1F601: icon = ICON_GRIN;
            21'h1F600: icon = ICON_GRIN;
            21'h1F603: icon = ICON_GRIN;
            21'h1F622: icon = 16'hF5B4;
            21'h1F914: icon = ICON_QMARK;
            21'h1F937: icon = ICON_QMARK;
            21'h1F606: icon = 16'hF59B;
            21'h1F644: icon = 16'hF5A5;
            21'h1F609: icon = 16'hF4DA;
            21'h1F917: icon = ICON_HUG;
            21'h1F614: icon = 16'hF119;
            21'h1F60E: icon = 16'hF530;
            21'h1F926: icon = 16'hF5C8;
            21'h1F631: icon = 16'hF5C2;
            21'h1F60B: icon = 16'hF589;
            21'h1F60F: icon = ICON_SMIRK;
            21'h1F612: icon = ICON_SMIRK;
            21'h1F929: icon = 16'hF587;
            21'h1F604: icon = 16'hF59A;
            21'h1F92D: icon = 16'hF118;
            21'h1F64F: icon = 16'hF684;
            21'h1F44D: icon = 16'hF164;
            21'h1F44F: icon = ICON_HUG;
            21'h1F64C: icon = ICON_HUG;
            21'h1F4AA: icon = 16'hF44B;
            21'h1F44C: icon = ICON_CHECK;
            21'h0270C: icon = 16'hF25B;
            21'h1F447: icon = 16'hF0A7;
            21'h02764: icon = ICON_HEART;
            21'h02665: icon = ICON_HEART;
            21'h02763: icon = ICON_HEART;
            21'h1F493: icon = ICON_HEART;
            21'h1F495: icon = ICON_HEART;
            21'h1F496: icon = ICON_HEART;
            21'h1F497: icon = ICON_HEART;
            21'h1F499: icon = ICON_HEART;
            21'h1F49A: icon = ICON_HEART;
            21'h1F49B: icon = ICON_HEART;
            21'h1F49C: icon = ICON_HEART;
            21'h1F49E: icon = ICON_HEART;
            21'h1F5A4: icon = ICON_HEART;
            21'h1F494: icon = 16'hF7A9;
            21'h1F525: icon = 16'hF06D;
            21'h1F339: icon = 16'hF5BB;
            21'h1F338: icon = 16'hF5BB;
            21'h1F389: icon = 16'hF79F;
            21'h02728: icon = 16'hF005;
            21'h1F648: icon = 16'hF070;
            21'h1F3B6: icon = 16'hF001;
            default:   icon = 16'h0000;
        endcase
        return icon;
    endfunction

endpackage

FILE: rtl/ugf_front.sv
// ugf_front: accepts input beats, assembles UTF-8 sequences and classifies
// each finished code point into a job of output bytes. Depends on ugf_pkg.
module ugf_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_in_byte,
    input  logic              s_in_last,
    input  logic              q_ready,
    output logic              q_push,
    output ugf_pkg::ugf_job_t q_job
);

    // sequence state
    logic [2:0]      seq_len_reg, seq_len_next;
    logic [2:0]      seq_seen_reg, seq_seen_next;
    logic [20:0]     code_acc_reg, code_acc_next;
    logic            seq_ok_reg, seq_ok_next;
    logic [3:0][7:0] raw_reg, raw_next;

    // classify stage
    logic                st_valid_reg;
    ugf_pkg::ugf_kind_t  st_kind_reg;
    logic [20:0]         st_cp_reg;
    logic [2:0]          st_len_reg;
    logic [3:0][7:0]     st_raw_reg;
    logic                st_last_reg;

    ugf_pkg::ugf_kind_t  ev_kind;
    logic [20:0]         ev_cp;
    logic [2:0]          ev_len;
    logic                accept;
    logic                need_push;
    logic                advance;
    logic [15:0]         icon;
    ugf_pkg::ugf_job_t   job;

    assign accept = s_valid && s_ready;

    always_comb begin
        seq_len_next  = seq_len_reg;
        seq_seen_next = seq_seen_reg;
        code_acc_next = code_acc_reg;
        seq_ok_next   = seq_ok_reg;
        raw_next      = raw_reg;
        ev_kind       = ugf_pkg::KIND_NONE;
        ev_cp         = {13'd0, s_in_byte};
        ev_len        = 3'd1;
        if (seq_len_reg == 3'd0) begin
            raw_next[0]   = s_in_byte;
            seq_seen_next = 3'd1;
            seq_ok_next   = 1'b1;
            if (!s_in_byte[7]) begin
                ev_kind       = ugf_pkg::KIND_FILT;
                seq_seen_next = 3'd0;
            end else if (s_in_byte[7:5] == 3'b110) begin
                seq_len_next  = 3'd2;
                code_acc_next = {16'd0, s_in_byte[4:0]};
            end else if (s_in_byte[7:4] == 4'b1110) begin
                seq_len_next  = 3'd3;
                code_acc_next = {17'd0, s_in_byte[3:0]};
            end else if (s_in_byte[7:3] == 5'b11110) begin
                seq_len_next  = 3'd4;
                code_acc_next = {18'd0, s_in_byte[2:0]};
            end else begin
                ev_kind       = ugf_pkg::KIND_REPL;
                seq_seen_next = 3'd0;
            end
        end else begin
            raw_next[seq_seen_reg[1:0]] = s_in_byte;
            if (seq_ok_reg) begin
                if (s_in_byte[7:6] != 2'b10) begin
                    seq_ok_next = 1'b0;
                end else begin
                    code_acc_next = {code_acc_reg[14:0], s_in_byte[5:0]};
                end
            end
            seq_seen_next = seq_seen_reg + 3'd1;
            if (seq_seen_next >= seq_len_reg) begin
                ev_kind       = seq_ok_next ? ugf_pkg::KIND_FILT : ugf_pkg::KIND_REPL;
                ev_cp         = code_acc_next;
                ev_len        = seq_len_reg;
                seq_len_next  = 3'd0;
                seq_seen_next = 3'd0;
                code_acc_next = 21'd0;
                seq_ok_next   = 1'b1;
            end
        end
        if (s_in_last) begin
            // string cut inside an open sequence
            if (seq_len_next != 3'd0) begin
                ev_kind = ugf_pkg::KIND_REPL;
            end
            seq_len_next  = 3'd0;
            seq_seen_next = 3'd0;
            code_acc_next = 21'd0;
            seq_ok_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_len_reg  <= 3'd0;
            seq_seen_reg <= 3'd0;
            code_acc_reg <= 21'd0;
            seq_ok_reg   <= 1'b1;
            st_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                seq_len_reg  <= seq_len_next;
                seq_seen_reg <= seq_seen_next;
                code_acc_reg <= code_acc_next;
                seq_ok_reg   <= seq_ok_next;
                st_valid_reg <= (ev_kind != ugf_pkg::KIND_NONE) || s_in_last;
            end else if (advance) begin
                st_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            raw_reg     <= raw_next;
            st_kind_reg <= ev_kind;
            st_cp_reg   <= ev_cp;
            st_len_reg  <= ev_len;
            st_raw_reg  <= raw_next;
            st_last_reg <= s_in_last;
        end
    end

    // classify
    assign icon = ugf_pkg::icon_of(st_cp_reg);

    always_comb begin
        job.bytes = '0;
        job.cnt   = 3'd0;
        job.data  = 1'b1;
        job.last  = st_last_reg;
        unique case (st_kind_reg)
            ugf_pkg::KIND_REPL: begin
                job.bytes[0] = 8'hEF;
                job.bytes[1] = 8'hBF;
                job.bytes[2] = 8'hBD;
                job.cnt      = 3'd3;
            end
            ugf_pkg::KIND_FILT: begin
                priority if (ugf_pkg::is_dropped(st_cp_reg)) begin
                    job.cnt = 3'd0;
                end else if (st_cp_reg == ugf_pkg::CP_DBL_EXCL) begin
                    job.bytes[0] = 8'h21;
                    job.bytes[1] = 8'h21;
                    job.cnt      = 3'd2;
                end else if (st_cp_reg == ugf_pkg::CP_HUNDRED) begin
                    job.bytes[0] = 8'h31;
                    job.bytes[1] = 8'h30;
                    job.bytes[2] = 8'h30;
                    job.cnt      = 3'd3;
                end else if (st_cp_reg == ugf_pkg::CP_NBSP ||
                             st_cp_reg == ugf_pkg::CP_NNBSP ||
                             st_cp_reg == ugf_pkg::CP_FIGSP) begin
                    job.bytes[0] = 8'h20;
                    job.cnt      = 3'd1;
                end else if (icon != 16'h0000) begin
                    job.bytes[0] = {4'hE, icon[15:12]};
                    job.bytes[1] = {2'b10, icon[11:6]};
                    job.bytes[2] = {2'b10, icon[5:0]};
                    job.cnt      = 3'd3;
                end else if (ugf_pkg::in_font(st_cp_reg)) begin
                    job.bytes = st_raw_reg;
                    job.cnt   = st_len_reg;
                end else begin
                    job.bytes[0] = 8'hEF;
                    job.bytes[1] = 8'hBF;
                    job.bytes[2] = 8'hBD;
                    job.cnt      = 3'd3;
                end
            end
            default: begin
                job.cnt = 3'd0;
            end
        endcase
        // end byte that yields nothing: empty marker
        if (job.cnt == 3'd0) begin
            job.bytes = '0;
            job.cnt   = 3'd1;
            job.data  = 1'b0;
        end
    end

    assign need_push = st_valid_reg && (job.data || st_last_reg);
    assign advance   = st_valid_reg && (!need_push || q_ready);
    assign q_push    = need_push && q_ready;
    assign q_job     = job;
    assign s_ready   = !st_valid_reg || advance;

endmodule

FILE: rtl/ugf_queue.sv
// ugf_queue: short job queue between front and back ends.
// Depends on ugf_pkg for the job type.
module ugf_queue #(
    parameter int DEPTH = ugf_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ugf_pkg::ugf_job_t din,
    output logic              ready,
    input  logic              pop,
    output ugf_pkg::ugf_job_t dout,
    output logic              nonempty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ugf_pkg::ugf_job_t mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg;

    assign ready    = count_reg != CW'(DEPTH);
    assign nonempty = count_reg != '0;
    assign dout     = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

FILE: rtl/ugf_back.sv
// ugf_back: takes jobs off the queue and sends their bytes, one beat per
// cycle while m_ready is high. Depends on ugf_pkg for the job type.
module ugf_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  ugf_pkg::ugf_job_t q_job,
    input  logic              q_nonempty,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_out_valid,
    output logic              m_out_run_last,
    output logic              m_out_string_end
);

    logic              work_valid_reg;
    ugf_pkg::ugf_job_t work_reg;
    logic [1:0]        idx_reg;
    logic              run_last;
    logic              load;

    assign run_last = ({1'b0, idx_reg} == (work_reg.cnt - 3'd1));
    assign load     = !work_valid_reg || (m_ready && run_last);
    assign q_pop    = load && q_nonempty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
        end else if (load) begin
            work_valid_reg <= q_nonempty;
            idx_reg        <= 2'd0;
        end else if (m_ready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            work_reg <= q_job;
        end
    end

    assign m_valid          = work_valid_reg;
    assign m_out_byte       = work_reg.bytes[idx_reg];
    assign m_out_valid      = work_reg.data;
    assign m_out_run_last   = run_last;
    assign m_out_string_end = run_last && work_reg.last;

endmodule

FILE: rtl/utf8_glyph_filter_decoder.sv
// utf8_glyph_filter_decoder: top level, front end, job queue and back end.
// Depends on ugf_pkg, ugf_front, ugf_queue and ugf_back.
//
// Takes a UTF-8 string one byte per beat (s_in_last on its final byte) and
// sends cleaned UTF-8 for a small display font, one byte per beat. Each input
// beat causes zero to four result beats; m_out_run_last marks the last one of
// an input beat and m_out_string_end the last one of the string. When the
// final byte yields no data, a single empty marker beat (m_out_valid 0,
// m_out_byte 0) closes the string. Bad lead bytes, bad continuations and cut
// sequences become U+FFFD; joiners, gender signs, selectors and skin tones
// are dropped; a few emoji become text or icon code points; glyphs outside
// the font become U+FFFD. Rate: the front end takes one byte per cycle while
// the job queue has room; the back end sends one result beat per cycle while
// m_ready is high, so a byte that yields up to four beats holds the back end
// until all are sent. A byte's first result beat passes the classify stage
// register, the queue and the work register. The job queue (QUEUE_DEPTH
// entries) lets the front end keep accepting while results wait on m_ready.
module utf8_glyph_filter_decoder #(
    parameter int QUEUE_DEPTH = ugf_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_valid,
    output logic       m_out_run_last,
    output logic       m_out_string_end
);

    ugf_pkg::ugf_job_t push_job;
    ugf_pkg::ugf_job_t head_job;
    logic              push;
    logic              q_ready;
    logic              pop;
    logic              q_nonempty;

    // decode + classify
    ugf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .q_ready   (q_ready),
        .q_push    (push),
        .q_job     (push_job)
    );

    // decouples input from result stalls
    ugf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .din      (push_job),
        .ready    (q_ready),
        .pop      (pop),
        .dout     (head_job),
        .nonempty (q_nonempty)
    );

    // byte serializer, doubles as the output register
    ugf_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_job            (head_job),
        .q_nonempty       (q_nonempty),
        .q_pop            (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_out_valid      (m_out_valid),
        .m_out_run_last   (m_out_run_last),
        .m_out_string_end (m_out_string_end)
    );

endmodule

FILE: rtl/ugf_checker.sv
// ugf_checker: port-level assertions for utf8_glyph_filter_decoder.
// Depends on the top level's ports only; bound to it below.
module ugf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_in_byte,
    input logic       s_in_last,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_out_valid,
    input logic       m_out_run_last,
    input logic       m_out_string_end
);

    // offered input beat holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_in_byte) && $stable(s_in_last))
        else $error("input beat changed while stalled");

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) &&
        $stable(m_out_string_end) && $stable(m_out_run_last))
        else $error("result beat changed while stalled");

    a_end_is_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_string_end |-> m_out_run_last)
        else $error("string end without run end");

    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_valid |-> m_out_string_end && m_out_byte == 8'd0)
        else $error("empty marker not at string end or nonzero");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

endmodule

bind utf8_glyph_filter_decoder ugf_checker u_ugf_checker (.*);
